>>> rtl/sed_pkg.sv
`default_nettype none
package sed_pkg;

    // input and output formats
    localparam int COORD_WIDTH     = 20;
    localparam int COORD_FRAC_BITS = 16;
    localparam int OUT_FRAC        = 16;
    localparam int RES_W           = 32;

    // configuration port
    localparam int ENT_W    = 16;
    localparam int NUM_ROWS = 3;
    localparam int ROW_W    = NUM_ROWS * ENT_W;
    localparam int APB_DW   = 64;
    localparam int APB_AW   = 5;
    localparam int IDX_W    = APB_AW - 3;

    localparam logic [IDX_W-1:0] REG_ROW0 = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_ROW1 = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_ROW2 = IDX_W'(2);

    // datapath widths
    localparam int PW     = (COORD_WIDTH > COORD_FRAC_BITS) ? COORD_WIDTH
                                                           : COORD_FRAC_BITS + 1;
    localparam int A_W    = PW + 18;
    localparam int M_W    = A_W - 1;
    localparam int SQ_LO  = M_W / 2;
    localparam int SQ_HI  = M_W - SQ_LO;
    localparam int SQR_W  = 2 * M_W;
    localparam int D_W    = 2 * A_W;
    localparam int S_W    = A_W;
    localparam int RT_W   = S_W + 3;
    localparam int N_W    = PW + A_W + 2;
    localparam int NM_W   = N_W - 1;
    localparam int NUM_W  = NM_W + OUT_FRAC;
    localparam int DEN_W  = S_W + COORD_FRAC_BITS;
    localparam int Q_W    = RES_W - 1;
    localparam int CW     = (NUM_W > DEN_W + Q_W + 1) ? NUM_W : DEN_W + Q_W + 1;

    localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

    typedef logic [NUM_ROWS-1:0][ROW_W-1:0] mat_t;

    // front end to square root
    typedef struct packed {
        logic            neg;
        logic [NM_W-1:0] magn;
        logic [D_W-1:0]  dsum;
    } fr_t;

    // square root to divider
    typedef struct packed {
        logic            neg;
        logic [NM_W-1:0] magn;
        logic [S_W-1:0]  root;
    } sr_t;

endpackage
`default_nettype wire

>>> rtl/sed_in_if.sv
`default_nettype none
interface sed_in_if;
    import sed_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;

    modport source (output valid, first_x, first_y, second_x, second_y, input ready);
    modport sink (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface
`default_nettype wire

>>> rtl/sed_out_if.sv
`default_nettype none
interface sed_out_if;
    import sed_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] residual;
    logic                    degenerate;

    modport source (output valid, residual, degenerate, input ready);
    modport sink (input valid, residual, degenerate, output ready);
endinterface
`default_nettype wire

>>> rtl/sed_regs.sv
`default_nettype none
module sed_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [sed_pkg::APB_AW-1:0] paddr,
    input  wire logic [sed_pkg::APB_DW-1:0] pwdata,
    output logic      [sed_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    output sed_pkg::mat_t                   rows
);
    import sed_pkg::*;

    mat_t             rows_reg;
    logic [IDX_W-1:0] idx;

    assign idx    = paddr[APB_AW-1:3];
    assign pready = 1'b1;
    assign rows   = rows_reg;

    // register write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_ROW0: rows_reg[0] <= pwdata[ROW_W-1:0];
                REG_ROW1: rows_reg[1] <= pwdata[ROW_W-1:0];
                REG_ROW2: rows_reg[2] <= pwdata[ROW_W-1:0];
                default:  ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            REG_ROW0: prdata = APB_DW'(rows_reg[0]);
            REG_ROW1: prdata = APB_DW'(rows_reg[1]);
            REG_ROW2: prdata = APB_DW'(rows_reg[2]);
            default:  prdata = '0;
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/sed_front.sv
`default_nettype none
module sed_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                adv,
    input  wire logic                                in_vld,
    input  wire logic signed [sed_pkg::COORD_WIDTH-1:0] x1,
    input  wire logic signed [sed_pkg::COORD_WIDTH-1:0] y1,
    input  wire logic signed [sed_pkg::COORD_WIDTH-1:0] x2,
    input  wire logic signed [sed_pkg::COORD_WIDTH-1:0] y2,
    input  wire sed_pkg::mat_t                       rows,
    output logic                                     out_vld,
    output sed_pkg::fr_t                             out_data
);
    import sed_pkg::*;

    localparam int P_W  = ENT_W + COORD_WIDTH;
    localparam int NP_W = COORD_WIDTH + A_W;

    logic signed [ENT_W-1:0] e [NUM_ROWS][NUM_ROWS];
    logic signed [P_W-1:0]   pa [NUM_ROWS][2];
    logic signed [P_W-1:0]   pb [2][2];

    // stage 1: a = E*x1, b = E^T*x2
    logic                          v1_reg;
    logic signed [A_W-1:0]         a_reg [NUM_ROWS];
    logic signed [A_W-1:0]         b_reg [2];
    logic signed [COORD_WIDTH-1:0] x2_reg, y2_reg;
    logic signed [A_W-1:0]         a_next [NUM_ROWS];
    logic signed [A_W-1:0]         b_next [2];

    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            for (int c = 0; c < NUM_ROWS; c++)
            begin
                e[r][c] = rows[r][ENT_W*c +: ENT_W];
            end
        end
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            pa[r][0]  = e[r][0] * x1;
            pa[r][1]  = e[r][1] * y1;
            a_next[r] = A_W'(pa[r][0]) + A_W'(pa[r][1])
                      + (A_W'(e[r][2]) <<< COORD_FRAC_BITS);
        end
        for (int c = 0; c < 2; c++)
        begin
            pb[c][0]  = e[0][c] * x2;
            pb[c][1]  = e[1][c] * y2;
            b_next[c] = A_W'(pb[c][0]) + A_W'(pb[c][1])
                      + (A_W'(e[2][c]) <<< COORD_FRAC_BITS);
        end
    end

    // stage 2: numerator products, magnitudes and split squares
    logic                    v2_reg;
    logic signed [NP_W-1:0]  n0_reg, n1_reg;
    logic signed [N_W-1:0]   n2_reg;
    logic [M_W+SQ_HI-1:0]    sh_reg [4];
    logic [M_W+SQ_LO-1:0]    sl_reg [4];
    logic [M_W-1:0]          m [4];
    logic signed [A_W-1:0]   vec [4];

    always_comb
    begin
        vec[0] = a_reg[0];
        vec[1] = a_reg[1];
        vec[2] = b_reg[0];
        vec[3] = b_reg[1];
        for (int i = 0; i < 4; i++)
        begin
            m[i] = M_W'(vec[i][A_W-1] ? -vec[i] : vec[i]);
        end
    end

    // stage 3: numerator sum, squares
    logic                   v3_reg;
    logic signed [N_W-1:0]  n_reg;
    logic [SQR_W-1:0]       sq_reg [4];

    // stage 4: denominator sum, sign and magnitude
    logic                   v4_reg;
    fr_t                    f4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg  <= a_next;
            b_reg  <= b_next;
            x2_reg <= x2;
            y2_reg <= y2;

            n0_reg <= x2_reg * a_reg[0];
            n1_reg <= y2_reg * a_reg[1];
            n2_reg <= N_W'(a_reg[2]) <<< COORD_FRAC_BITS;
            for (int i = 0; i < 4; i++)
            begin
                sh_reg[i] <= m[i] * m[i][M_W-1:SQ_LO];
                sl_reg[i] <= m[i] * m[i][SQ_LO-1:0];
            end

            n_reg <= N_W'(n0_reg) + N_W'(n1_reg) + n2_reg;
            for (int i = 0; i < 4; i++)
            begin
                sq_reg[i] <= (SQR_W'(sh_reg[i]) << SQ_LO) + SQR_W'(sl_reg[i]);
            end

            f4_reg.neg  <= n_reg[N_W-1];
            f4_reg.magn <= NM_W'(n_reg[N_W-1] ? -n_reg : n_reg);
            f4_reg.dsum <= D_W'(sq_reg[0]) + D_W'(sq_reg[1])
                         + D_W'(sq_reg[2]) + D_W'(sq_reg[3]);
        end
    end

    assign out_vld  = v4_reg;
    assign out_data = f4_reg;
endmodule
`default_nettype wire

>>> rtl/sed_sqrt.sv
`default_nettype none
module sed_sqrt (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         adv,
    input  wire logic         in_vld,
    input  wire sed_pkg::fr_t in_data,
    output logic              out_vld,
    output sed_pkg::sr_t      out_data
);
    import sed_pkg::*;

    typedef struct packed {
        logic             neg;
        logic [NM_W-1:0]  magn;
        logic [D_W-1:0]   rad;
        logic [RT_W-1:0]  rem;
        logic [S_W-1:0]   root;
    } sq_st_t;

    sq_st_t st_reg  [1:S_W];
    logic   vld_reg [1:S_W];

    // one root bit per stage, restoring digit recurrence
    for (genvar i = 0; i < S_W; i++)
    begin : g_step
        sq_st_t          prev;
        sq_st_t          nxt;
        logic            prev_vld;
        logic [RT_W-1:0] rem_t;
        logic [RT_W-1:0] trial;

        if (i == 0)
        begin : g_first
            assign prev.neg  = in_data.neg;
            assign prev.magn = in_data.magn;
            assign prev.rad  = in_data.dsum;
            assign prev.rem  = '0;
            assign prev.root = '0;
            assign prev_vld  = in_vld;
        end
        else
        begin : g_next
            assign prev     = st_reg[i];
            assign prev_vld = vld_reg[i];
        end

        always_comb
        begin
            rem_t = {prev.rem[RT_W-3:0], prev.rad[D_W-1:D_W-2]};
            trial = RT_W'({prev.root, 2'b01});
            nxt      = prev;
            nxt.rad  = {prev.rad[D_W-3:0], 2'b00};
            if (rem_t >= trial)
            begin
                nxt.rem  = rem_t - trial;
                nxt.root = {prev.root[S_W-2:0], 1'b1};
            end
            else
            begin
                nxt.rem  = rem_t;
                nxt.root = {prev.root[S_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[i+1] <= prev_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[i+1] <= nxt;
            end
        end
    end

    assign out_vld       = vld_reg[S_W];
    assign out_data.neg  = st_reg[S_W].neg;
    assign out_data.magn = st_reg[S_W].magn;
    assign out_data.root = st_reg[S_W].root;
endmodule
`default_nettype wire

>>> rtl/sed_div.sv
`default_nettype none
module sed_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           adv,
    input  wire logic                           in_vld,
    input  wire sed_pkg::sr_t                   in_data,
    output logic                                out_vld,
    output logic signed [sed_pkg::RES_W-1:0]    residual,
    output logic                                degenerate
);
    import sed_pkg::*;

    typedef struct packed {
        logic             neg;
        logic             degen;
        logic             sat;
        logic [CW-1:0]    rem;
        logic [DEN_W-1:0] den;
        logic [Q_W-1:0]   q;
    } dv_st_t;

    dv_st_t dv_reg  [0:Q_W];
    logic   vld_reg [0:Q_W];

    // setup: scale operands, overflow test against the top quotient weight
    dv_st_t        setup;
    logic [CW-1:0] num;

    always_comb
    begin
        num         = CW'(in_data.magn) << OUT_FRAC;
        setup.neg   = in_data.neg;
        setup.degen = (in_data.root == '0);
        setup.den   = DEN_W'(in_data.root) << COORD_FRAC_BITS;
        setup.sat   = (num >= (CW'(setup.den) << Q_W));
        setup.rem   = num;
        setup.q     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_reg[0] <= setup;
        end
    end

    // one quotient bit per stage, msb first
    for (genvar i = 0; i < Q_W; i++)
    begin : g_step
        localparam int K = Q_W - 1 - i;
        dv_st_t        nxt;
        logic [CW-1:0] dsh;

        always_comb
        begin
            dsh = CW'(dv_reg[i].den) << K;
            nxt = dv_reg[i];
            if (dv_reg[i].rem >= dsh)
            begin
                nxt.rem  = dv_reg[i].rem - dsh;
                nxt.q[K] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[i+1] <= nxt;
            end
        end
    end

    // output register: sign, saturation, degenerate case
    dv_st_t                  fin;
    logic                    out_vld_reg;
    logic signed [RES_W-1:0] res_reg, res_next;
    logic                    degen_reg;

    assign fin = dv_reg[Q_W];

    always_comb
    begin
        priority if (fin.degen)
        begin
            res_next = '0;
        end
        else if (fin.sat)
        begin
            res_next = fin.neg ? RES_MIN : RES_MAX;
        end
        else if (fin.neg)
        begin
            res_next = -$signed({1'b0, fin.q});
        end
        else
        begin
            res_next = $signed({1'b0, fin.q});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= vld_reg[Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg   <= res_next;
            degen_reg <= fin.degen;
        end
    end

    assign out_vld    = out_vld_reg;
    assign residual   = res_reg;
    assign degenerate = degen_reg;
endmodule
`default_nettype wire

>>> rtl/sampson_epipolar_distance_core.sv
// Sampson epipolar distance of one point correspondence per transaction under the
// essential matrix held in the three row registers (APB byte addresses 0, 8, 16).
// The block takes one correspondence every cycle and returns its residual after
// the stages for the matrix products, numerator and sum of squares, the
// bit-per-stage square root, divider setup, the bit-per-stage quotient and the
// output register. When a result is not taken the whole pipeline holds, and
// input ready drops until it moves again.
// Rewrite the matrix only with no transaction in flight.
`default_nettype none
module sampson_epipolar_distance_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [sed_pkg::APB_AW-1:0] paddr,
    input  wire logic [sed_pkg::APB_DW-1:0] pwdata,
    output logic      [sed_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    sed_in_if.sink                          corr,
    sed_out_if.source                       res
);
    import sed_pkg::*;

    mat_t rows;
    logic adv;
    logic fr_vld, sr_vld;
    fr_t  fr_data;
    sr_t  sr_data;

    // global advance: hold everything while the result waits
    assign adv        = !res.valid || res.ready;
    assign corr.ready = adv;

    sed_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .rows    (rows)
    );

    sed_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (corr.valid),
        .x1       (corr.first_x),
        .y1       (corr.first_y),
        .x2       (corr.second_x),
        .y2       (corr.second_y),
        .rows     (rows),
        .out_vld  (fr_vld),
        .out_data (fr_data)
    );

    sed_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (fr_vld),
        .in_data  (fr_data),
        .out_vld  (sr_vld),
        .out_data (sr_data)
    );

    sed_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_vld     (sr_vld),
        .in_data    (sr_data),
        .out_vld    (res.valid),
        .residual   (res.residual),
        .degenerate (res.degenerate)
    );
endmodule
`default_nettype wire

>>> rtl/sed_checker.sv
`default_nettype none
module sed_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_ready,
    input  wire logic                           out_valid,
    input  wire logic                           out_ready,
    input  wire logic signed [sed_pkg::RES_W-1:0] residual,
    input  wire logic                           degenerate
);
    import sed_pkg::*;

    // degenerate results carry a zero residual
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> residual == '0)
        else $error("degenerate result with nonzero residual");

    // a stalled result blocks the input side
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while result stalled");

    // a stalled result holds its value
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(residual) && $stable(degenerate))
        else $error("stalled result changed");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid out of reset");
endmodule

bind sampson_epipolar_distance_core sed_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (corr.ready),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .residual   (res.residual),
    .degenerate (res.degenerate)
);
`default_nettype wire
